FILE: hw/rtl/gbi_pkg.sv
package gbi_pkg;

  // Width of the shared datapath; holds the largest numerator (G*m*|d| << frac)
  localparam int EW           = 130;
  // Quotient bits produced by the divider; larger quotients clip to the cap
  localparam int QB           = 34;
  localparam int CAP_BIT      = 33;
  // Root digits of the square root (radicand window is 2*SQ_STEPS bits)
  localparam int SQ_STEPS     = 35;
  // Signed width of the collide numerator
  localparam int SW           = 68;
  localparam int FRAC_BITS_DEF = 16;
  localparam int AW           = 5;

  typedef enum logic [1:0] {
    EM_MUL,
    EM_DIV,
    EM_SQRT
  } eng_mode_t;

  typedef struct packed {
    logic            start;
    eng_mode_t       mode;
    logic [EW-1:0]   a;
    logic [EW-1:0]   b;
    logic [EW-1:0]   c;
  } eng_req_t;

  typedef struct packed {
    logic            done;
    logic [EW-1:0]   res;
  } eng_rsp_t;

  typedef struct packed {
    logic [31:0] grav;
    logic [31:0] mass;
    logic        fixed;
  } cfg_t;

  typedef struct packed {
    logic        px;
    logic        py;
    logic        vx;
    logic        vy;
    logic [31:0] val;
  } ld_t;

endpackage

FILE: hw/rtl/gbi_engine.sv
module gbi_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  gbi_pkg::eng_req_t req,
  output gbi_pkg::eng_rsp_t rsp
);

  localparam int EW = gbi_pkg::EW;
  localparam int QB = gbi_pkg::QB;
  localparam int SQ = gbi_pkg::SQ_STEPS;
  localparam logic [EW-1:0] CAP = EW'(1) << gbi_pkg::CAP_BIT;

  logic                busy_r;
  logic                done_r;
  logic                first_r;
  logic                ovf_r;
  gbi_pkg::eng_mode_t  mode_r;
  logic [EW-1:0]       p_r;
  logic [EW-1:0]       a_r;
  logic [EW-1:0]       b_r;
  logic [EW-1:0]       d_r;
  logic [5:0]          cnt_r;

  logic [EW-1:0]       rn_div;
  logic [EW-1:0]       rn_sq;
  logic [EW-1:0]       trial;
  logic [EW-1:0]       op_x;
  logic [EW-1:0]       op_y;
  logic [EW-1:0]       cap_q;
  logic                sub;
  logic [EW:0]         sum_w;
  logic                ge;

  assign rn_div = {p_r[EW-2:0], a_r[QB-1]};
  assign rn_sq  = {p_r[EW-3:0], a_r[2*SQ-1 -: 2]};
  assign trial  = {b_r[EW-3:0], 2'b01};

  // One adder serves multiply accumulate, divide and root trial subtracts
  always_comb begin
    op_x = p_r;
    op_y = a_r;
    sub  = 1'b0;
    case (mode_r)
      gbi_pkg::EM_DIV: begin
        op_x = first_r ? p_r : rn_div;
        op_y = d_r;
        sub  = 1'b1;
      end
      gbi_pkg::EM_SQRT: begin
        op_x = rn_sq;
        op_y = trial;
        sub  = 1'b1;
      end
      default: begin
        op_x = p_r;
        op_y = a_r;
        sub  = 1'b0;
      end
    endcase
  end

  assign sum_w = {1'b0, op_x} + {1'b0, (sub ? ~op_y : op_y)} + {{EW{1'b0}}, sub};
  assign ge    = sum_w[EW];

  assign cap_q = (ovf_r || (b_r > CAP)) ? CAP : b_r;

  always_comb begin
    rsp.done = done_r;
    case (mode_r)
      gbi_pkg::EM_DIV:  rsp.res = cap_q;
      gbi_pkg::EM_SQRT: rsp.res = b_r;
      default:          rsp.res = p_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r  <= 1'b1;
        mode_r  <= req.mode;
        first_r <= 1'b1;
        ovf_r   <= 1'b0;
        case (req.mode)
          gbi_pkg::EM_DIV: begin
            p_r   <= req.a >> QB;
            a_r   <= req.a;
            b_r   <= '0;
            d_r   <= req.b;
            cnt_r <= 6'(QB);
          end
          gbi_pkg::EM_SQRT: begin
            p_r   <= '0;
            a_r   <= req.a;
            b_r   <= '0;
            cnt_r <= 6'(SQ);
          end
          default: begin
            p_r <= req.c;
            a_r <= req.a;
            b_r <= req.b;
          end
        endcase
      end else if (busy_r) begin
        case (mode_r)
          gbi_pkg::EM_DIV: begin
            if (first_r) begin
              first_r <= 1'b0;
              // quotient would not fit the digit window: clip
              if (ge) begin
                ovf_r  <= 1'b1;
                busy_r <= 1'b0;
                done_r <= 1'b1;
              end
            end else begin
              p_r   <= ge ? sum_w[EW-1:0] : rn_div;
              b_r   <= {b_r[EW-2:0], ge};
              a_r   <= a_r << 1;
              cnt_r <= cnt_r - 6'd1;
              if (cnt_r == 6'd1) begin
                busy_r <= 1'b0;
                done_r <= 1'b1;
              end
            end
          end
          gbi_pkg::EM_SQRT: begin
            p_r   <= ge ? sum_w[EW-1:0] : rn_sq;
            b_r   <= {b_r[EW-2:0], ge};
            a_r   <= a_r << 2;
            cnt_r <= cnt_r - 6'd1;
            if (cnt_r == 6'd1) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
          default: begin
            if (b_r == '0) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end else begin
              if (b_r[0]) begin
                p_r <= sum_w[EW-1:0];
              end
              a_r <= a_r << 1;
              b_r <= b_r >> 1;
            end
          end
        endcase
      end
    end
  end

endmodule

FILE: hw/rtl/gbi_apb.sv
module gbi_apb #(
  parameter int FRAC_BITS = gbi_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [gbi_pkg::AW-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output gbi_pkg::cfg_t          cfg,
  output gbi_pkg::ld_t           ld
);

  typedef enum logic [2:0] {
    R_GRAV,
    R_MASS,
    R_FIXED,
    R_SX,
    R_SY,
    R_SVX,
    R_SVY
  } reg_idx_t;

  localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

  logic [31:0] grav_r;
  logic [31:0] mass_r;
  logic        fixed_r;
  logic [31:0] sx_r;
  logic [31:0] sy_r;
  logic [31:0] svx_r;
  logic [31:0] svy_r;
  logic        wr;
  reg_idx_t    idx;

  assign wr  = psel && penable && pwrite;
  assign idx = reg_idx_t'(paddr[gbi_pkg::AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r  <= ONE;
      mass_r  <= ONE;
      fixed_r <= 1'b0;
      sx_r    <= '0;
      sy_r    <= '0;
      svx_r   <= '0;
      svy_r   <= '0;
    end else if (wr) begin
      case (idx)
        R_GRAV:  grav_r  <= pwdata;
        R_MASS:  mass_r  <= pwdata;
        R_FIXED: fixed_r <= pwdata[0];
        R_SX:    sx_r    <= pwdata;
        R_SY:    sy_r    <= pwdata;
        R_SVX:   svx_r   <= pwdata;
        R_SVY:   svy_r   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      R_GRAV:  prdata = grav_r;
      R_MASS:  prdata = mass_r;
      R_FIXED: prdata = {31'd0, fixed_r};
      R_SX:    prdata = sx_r;
      R_SY:    prdata = sy_r;
      R_SVX:   prdata = svx_r;
      R_SVY:   prdata = svy_r;
      default: prdata = '0;
    endcase
  end

  assign cfg.grav  = grav_r;
  assign cfg.mass  = mass_r;
  assign cfg.fixed = fixed_r;

  // start registers also load the body state as they are written
  assign ld.px  = wr && (idx == R_SX);
  assign ld.py  = wr && (idx == R_SY);
  assign ld.vx  = wr && (idx == R_SVX);
  assign ld.vy  = wr && (idx == R_SVY);
  assign ld.val = pwdata;

endmodule

FILE: hw/rtl/gravity_body_integrator_core.sv
// One body under Newtonian gravity, state in signed fixed point.
// Input channel (in_*): one item per op: attract, collide, integrate or
// clear acceleration. in_stall is high from acceptance until the result is
// handed to the output register, so one item is in work at a time.
// Result channel (out_*): one item per input item with the body's position
// and velocity after the step plus zero_distance and saturated flags. The
// output register frees the engine: a stalled result holds while the next
// item is already accepted and worked on.
// A single shared add/subtract unit iterates multiplies (one multiplier bit a
// cycle), the square root (one root bit a cycle, 35 root bits) and divides
// (one quotient bit a cycle, 34 quotient bits), and attract runs nine of these
// operations back to back.
// Configuration goes through the cfg_* APB port and is for the user to write
// only while the block is idle; the block itself does not enforce this.
// Writing a start register loads that position or velocity at once.
// Reset (rst_n low, synchronous) restores register defaults, zeroes the
// body state and drops out_valid.
module gravity_body_integrator_core #(
  parameter int FRAC_BITS = gbi_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_op,
  input  logic signed [31:0]     in_other_x,
  input  logic signed [31:0]     in_other_y,
  input  logic [31:0]            in_other_mass,
  input  logic signed [31:0]     in_other_vx,
  input  logic signed [31:0]     in_other_vy,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [31:0]     out_pos_x,
  output logic signed [31:0]     out_pos_y,
  output logic signed [31:0]     out_vel_x,
  output logic signed [31:0]     out_vel_y,
  output logic                   out_zero_distance,
  output logic                   out_saturated,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [gbi_pkg::AW-1:0] cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  localparam int EW = gbi_pkg::EW;
  localparam int SW = gbi_pkg::SW;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ATT_SQ1,
    S_ATT_SQ2,
    S_ATT_RT,
    S_ATT_D3,
    S_ATT_GM,
    S_ATT_N,
    S_ATT_Q,
    S_COL_T1,
    S_COL_T2,
    S_COL_Q,
    S_INT,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_ATTRACT,
    OP_COLLIDE,
    OP_INTEGRATE,
    OP_CLEAR
  } op_t;

  function automatic logic [32:0] sat36(logic signed [35:0] v);
    logic [32:0] r;
    if (v > 36'sd2147483647) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (v < -36'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  function automatic logic signed [35:0] sx36(logic [31:0] v);
    return {{4{v[31]}}, v};
  endfunction

  gbi_pkg::cfg_t     cfg;
  gbi_pkg::ld_t      ld;
  gbi_pkg::eng_req_t eng_req;
  gbi_pkg::eng_rsp_t eng_rsp;

  state_t                 state_r;
  logic                   go_r;
  logic                   axis_r;
  logic signed [32:0]     dx_r;
  logic signed [32:0]     dy_r;
  logic [31:0]            om_r;
  logic signed [31:0]     ovx_r;
  logic signed [31:0]     ovy_r;
  logic signed [31:0]     px_r;
  logic signed [31:0]     py_r;
  logic signed [31:0]     vx_r;
  logic signed [31:0]     vy_r;
  logic signed [31:0]     ax_r;
  logic signed [31:0]     ay_r;
  logic [65:0]            d2_r;
  logic [99:0]            d3_r;
  logic [63:0]            gm_r;
  logic signed [SW-1:0]   t1s_r;
  logic signed [SW-1:0]   sum_r;
  logic                   zero_r;
  logic                   sat_r;
  logic                   out_valid_r;
  logic signed [31:0]     out_px_r;
  logic signed [31:0]     out_py_r;
  logic signed [31:0]     out_vx_r;
  logic signed [31:0]     out_vy_r;
  logic                   out_zero_r;
  logic                   out_sat_r;

  logic                   in_acc;
  logic signed [32:0]     dx_in;
  logic signed [32:0]     dy_in;
  logic [32:0]            msum_in;
  logic [32:0]            mag_dx;
  logic [32:0]            mag_dy;
  logic signed [31:0]     cur_v;
  logic signed [31:0]     cur_vo;
  logic [31:0]            mag_v;
  logic [31:0]            mag_vo;
  logic                   m_lt;
  logic [31:0]            dm;
  logic [32:0]            msum;
  logic                   n1;
  logic                   n2;
  logic signed [SW-1:0]   prod_s;
  logic signed [SW-1:0]   t2s;
  logic [SW-1:0]          mag_sum;
  logic signed [32:0]     cur_d;
  logic signed [31:0]     cur_acc;
  logic                   d_pos;
  logic signed [35:0]     mag36;
  logic signed [35:0]     att_sum;
  logic [32:0]            att_s;
  logic [32:0]            col_s;
  logic [32:0]            ivx_s;
  logic [32:0]            ivy_s;
  logic [32:0]            ipx_s;
  logic [32:0]            ipy_s;

  gbi_apb #(
    .FRAC_BITS(FRAC_BITS)
  ) u_apb (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg),
    .ld      (ld)
  );

  gbi_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (eng_req),
    .rsp   (eng_rsp)
  );

  assign cfg_pready = 1'b1;
  assign in_stall   = (state_r != S_IDLE);
  assign in_acc     = in_valid && !in_stall;

  assign dx_in   = {px_r[31], px_r} - {in_other_x[31], in_other_x};
  assign dy_in   = {py_r[31], py_r} - {in_other_y[31], in_other_y};
  assign msum_in = {1'b0, cfg.mass} + {1'b0, in_other_mass};

  assign mag_dx = dx_r[32] ? 33'(-dx_r) : 33'(dx_r);
  assign mag_dy = dy_r[32] ? 33'(-dy_r) : 33'(dy_r);

  assign cur_v  = axis_r ? vy_r : vx_r;
  assign cur_vo = axis_r ? ovy_r : ovx_r;
  assign mag_v  = cur_v[31] ? 32'(-cur_v) : 32'(cur_v);
  assign mag_vo = cur_vo[31] ? 32'(-cur_vo) : 32'(cur_vo);
  assign m_lt   = cfg.mass < om_r;
  assign dm     = m_lt ? (om_r - cfg.mass) : (cfg.mass - om_r);
  assign msum   = {1'b0, cfg.mass} + {1'b0, om_r};
  assign n1     = m_lt ^ cur_v[31];
  assign n2     = cur_vo[31];

  assign prod_s  = $signed(eng_rsp.res[SW-1:0]);
  assign t2s     = n2 ? -prod_s : prod_s;
  assign mag_sum = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);

  // capped quotient, signed toward the other body (attract) or by the sum
  assign mag36   = $signed({2'b00, eng_rsp.res[33:0]});
  assign cur_d   = axis_r ? dy_r : dx_r;
  assign cur_acc = axis_r ? ay_r : ax_r;
  assign d_pos   = !cur_d[32] && (cur_d != '0);
  assign att_sum = sx36(cur_acc) + (d_pos ? -mag36 : mag36);
  assign att_s   = sat36(att_sum);
  assign col_s   = sat36(sum_r[SW-1] ? -mag36 : mag36);

  assign ivx_s = sat36(sx36(vx_r) + sx36(ax_r));
  assign ivy_s = sat36(sx36(vy_r) + sx36(ay_r));
  assign ipx_s = sat36(sx36(px_r) + sx36(ivx_s[31:0]));
  assign ipy_s = sat36(sx36(py_r) + sx36(ivy_s[31:0]));

  always_comb begin
    eng_req       = '0;
    eng_req.start = go_r;
    eng_req.mode  = gbi_pkg::EM_MUL;
    case (state_r)
      S_ATT_SQ1: begin
        eng_req.a = EW'(mag_dx);
        eng_req.b = EW'(mag_dx);
      end
      S_ATT_SQ2: begin
        eng_req.a = EW'(mag_dy);
        eng_req.b = EW'(mag_dy);
        eng_req.c = eng_rsp.res;
      end
      S_ATT_RT: begin
        eng_req.mode = gbi_pkg::EM_SQRT;
        eng_req.a    = EW'(d2_r);
      end
      S_ATT_D3: begin
        eng_req.a = EW'(d2_r);
        eng_req.b = eng_rsp.res;
      end
      S_ATT_GM: begin
        eng_req.a = EW'(cfg.grav);
        eng_req.b = EW'(om_r);
      end
      S_ATT_N: begin
        eng_req.a = EW'(gm_r);
        eng_req.b = EW'(axis_r ? mag_dy : mag_dx);
      end
      S_ATT_Q: begin
        eng_req.mode = gbi_pkg::EM_DIV;
        eng_req.a    = eng_rsp.res << FRAC_BITS;
        eng_req.b    = EW'(d3_r);
      end
      S_COL_T1: begin
        eng_req.a = EW'(dm);
        eng_req.b = EW'(mag_v);
      end
      S_COL_T2: begin
        eng_req.a = EW'({om_r, 1'b0});
        eng_req.b = EW'(mag_vo);
      end
      S_COL_Q: begin
        eng_req.mode = gbi_pkg::EM_DIV;
        eng_req.a    = EW'(mag_sum);
        eng_req.b    = EW'(msum);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      go_r        <= 1'b0;
      axis_r      <= 1'b0;
      px_r        <= '0;
      py_r        <= '0;
      vx_r        <= '0;
      vy_r        <= '0;
      ax_r        <= '0;
      ay_r        <= '0;
      zero_r      <= 1'b0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      go_r <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (ld.px) px_r <= ld.val;
      if (ld.py) py_r <= ld.val;
      if (ld.vx) vx_r <= ld.val;
      if (ld.vy) vy_r <= ld.val;

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            zero_r <= 1'b0;
            sat_r  <= 1'b0;
            axis_r <= 1'b0;
            om_r   <= in_other_mass;
            ovx_r  <= in_other_vx;
            ovy_r  <= in_other_vy;
            dx_r   <= dx_in;
            dy_r   <= dy_in;
            case (op_t'(in_op))
              OP_ATTRACT: begin
                if ((dx_in == '0) && (dy_in == '0)) begin
                  zero_r  <= 1'b1;
                  state_r <= S_DONE;
                end else begin
                  state_r <= S_ATT_SQ1;
                  go_r    <= 1'b1;
                end
              end
              OP_COLLIDE: begin
                // both masses zero: leave velocity alone
                if (msum_in == '0) begin
                  state_r <= S_DONE;
                end else begin
                  state_r <= S_COL_T1;
                  go_r    <= 1'b1;
                end
              end
              OP_INTEGRATE: state_r <= S_INT;
              OP_CLEAR: begin
                ax_r    <= '0;
                ay_r    <= '0;
                state_r <= S_DONE;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_ATT_SQ1: begin
          if (eng_rsp.done) begin
            state_r <= S_ATT_SQ2;
            go_r    <= 1'b1;
          end
        end
        S_ATT_SQ2: begin
          if (eng_rsp.done) begin
            d2_r    <= eng_rsp.res[65:0];
            state_r <= S_ATT_RT;
            go_r    <= 1'b1;
          end
        end
        S_ATT_RT: begin
          if (eng_rsp.done) begin
            state_r <= S_ATT_D3;
            go_r    <= 1'b1;
          end
        end
        S_ATT_D3: begin
          if (eng_rsp.done) begin
            d3_r    <= eng_rsp.res[99:0];
            state_r <= S_ATT_GM;
            go_r    <= 1'b1;
          end
        end
        S_ATT_GM: begin
          if (eng_rsp.done) begin
            gm_r    <= eng_rsp.res[63:0];
            state_r <= S_ATT_N;
            go_r    <= 1'b1;
          end
        end
        S_ATT_N: begin
          if (eng_rsp.done) begin
            state_r <= S_ATT_Q;
            go_r    <= 1'b1;
          end
        end
        S_ATT_Q: begin
          if (eng_rsp.done) begin
            if (axis_r) begin
              ay_r <= att_s[31:0];
            end else begin
              ax_r <= att_s[31:0];
            end
            sat_r <= sat_r | att_s[32];
            if (axis_r) begin
              state_r <= S_DONE;
            end else begin
              axis_r  <= 1'b1;
              state_r <= S_ATT_N;
              go_r    <= 1'b1;
            end
          end
        end
        S_COL_T1: begin
          if (eng_rsp.done) begin
            t1s_r   <= n1 ? -prod_s : prod_s;
            state_r <= S_COL_T2;
            go_r    <= 1'b1;
          end
        end
        S_COL_T2: begin
          if (eng_rsp.done) begin
            sum_r   <= t1s_r + t2s;
            state_r <= S_COL_Q;
            go_r    <= 1'b1;
          end
        end
        S_COL_Q: begin
          if (eng_rsp.done) begin
            if (axis_r) begin
              vy_r <= col_s[31:0];
            end else begin
              vx_r <= col_s[31:0];
            end
            sat_r <= sat_r | col_s[32];
            if (axis_r) begin
              state_r <= S_DONE;
            end else begin
              axis_r  <= 1'b1;
              state_r <= S_COL_T1;
              go_r    <= 1'b1;
            end
          end
        end
        S_INT: begin
          if (!cfg.fixed) begin
            vx_r  <= ivx_s[31:0];
            vy_r  <= ivy_s[31:0];
            px_r  <= ipx_s[31:0];
            py_r  <= ipy_s[31:0];
            sat_r <= ivx_s[32] | ivy_s[32] | ipx_s[32] | ipy_s[32];
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_px_r    <= px_r;
            out_py_r    <= py_r;
            out_vx_r    <= vx_r;
            out_vy_r    <= vy_r;
            out_zero_r  <= zero_r;
            out_sat_r   <= sat_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pos_x         = out_px_r;
  assign out_pos_y         = out_py_r;
  assign out_vel_x         = out_vx_r;
  assign out_vel_y         = out_vy_r;
  assign out_zero_distance = out_zero_r;
  assign out_saturated     = out_sat_r;

endmodule

FILE: hw/rtl/gbi_chk.sv
module gbi_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_pos_x,
  input logic [31:0] out_pos_y,
  input logic [31:0] out_vel_x,
  input logic [31:0] out_vel_y,
  input logic        out_zero_distance,
  input logic        out_saturated
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pos_x) && $stable(out_pos_y)
      && $stable(out_vel_x) && $stable(out_vel_y))
    else $error("stalled result item changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in work");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_zero_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_distance |-> !out_saturated)
    else $error("zero distance item reports saturation");

endmodule

bind gravity_body_integrator_core gbi_chk u_gbi_chk (.*);

FILE: tb/gravity_body_integrator_core_tb.sv
module gravity_body_integrator_core_tb;

  localparam logic [1:0] OP_ATTRACT   = 2'd0;
  localparam logic [1:0] OP_COLLIDE   = 2'd1;
  localparam logic [1:0] OP_INTEGRATE = 2'd2;
  localparam logic [1:0] OP_CLEAR     = 2'd3;

  localparam int REG_GRAV     = 0;
  localparam int REG_MASS     = 1;
  localparam int REG_FIXED    = 2;
  localparam int REG_START_X  = 3;
  localparam int REG_START_Y  = 4;
  localparam int REG_START_VX = 5;
  localparam int REG_START_VY = 6;
  localparam int REG_UNUSED   = 7;

  localparam int FRAC = 16;
  localparam int STALL_LIMIT = 5000;
  localparam logic [127:0] QCAP = 128'h2_0000_0000;

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic [31:0]        om;
    logic signed [31:0] ovx;
    logic signed [31:0] ovy;
    bit                 near;
  } body_item_t;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               zd;
    logic               sat;
  } body_state_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_op = '0;
  logic signed [31:0] in_other_x = '0, in_other_y = '0, in_other_vx = '0, in_other_vy = '0;
  logic [31:0] in_other_mass = '0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] out_pos_x, out_pos_y, out_vel_x, out_vel_y;
  logic out_zero_distance, out_saturated;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [gbi_pkg::AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  gravity_body_integrator_core uut (.*);

  always #1 clk = ~clk;

  // predicted body state and registers
  logic [31:0] g_const = 32'h1_0000, m_own = 32'h1_0000;
  bit body_fix = 0;
  logic signed [31:0] pos_x = 0, pos_y = 0, vel_x = 0, vel_y = 0, acc_x = 0, acc_y = 0;

  body_item_t  pending_items[$];
  body_state_t expected_states[$];
  body_item_t  cur;
  int gap, stall_left, idle_cycles, fails, popped;
  bit calm;

  function automatic logic signed [31:0] clip32(input logic signed [127:0] v, inout bit f);
    if (v > 128'sd2147483647) begin
      f = 1;
      return 32'sh7fff_ffff;
    end
    if (v < -128'sd2147483648) begin
      f = 1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic [127:0] isqrt(input logic [127:0] v);
    logic [127:0] r, c;
    r = 0;
    for (int b = 34; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] pull_axis(input logic signed [31:0] acc,
      input logic signed [127:0] delta, input logic [127:0] gm, input logic [127:0] d3,
      inout bit f);
    logic [127:0] mag, q;
    mag = delta < 0 ? -delta : delta;
    q = ((gm * mag) << FRAC) / d3;
    if (q > QCAP) q = QCAP;
    return clip32($signed(acc) + (delta > 0 ? -$signed(q) : $signed(q)), f);
  endfunction

  function automatic logic signed [31:0] bounce_axis(input logic signed [31:0] v,
      input logic signed [31:0] vo, input logic [31:0] m_other, inout bit f);
    logic signed [127:0] m1, m2, n, sv, svo;
    logic [127:0] mag, den;
    m1 = {96'd0, m_own};
    m2 = {96'd0, m_other};
    sv = v;
    svo = vo;
    n = (m1 - m2) * sv + 2 * m2 * svo;
    den = m1 + m2;
    mag = (n < 0 ? -n : n);
    mag = mag / den;
    if (mag > QCAP) mag = QCAP;
    return clip32(n < 0 ? -$signed(mag) : $signed(mag), f);
  endfunction

  task automatic step_body(input body_item_t it);
    body_state_t r;
    bit f;
    logic signed [127:0] dx, dy;
    logic [127:0] ax, ay, d2, d3, gm;
    f = 0;
    r.zd = 0;
    case (it.op)
      OP_ATTRACT: begin
        dx = $signed(pos_x) - $signed(it.ox);
        dy = $signed(pos_y) - $signed(it.oy);
        if (dx == 0 && dy == 0) r.zd = 1;
        else begin
          ax = dx < 0 ? -dx : dx;
          ay = dy < 0 ? -dy : dy;
          d2 = ax * ax + ay * ay;
          d3 = d2 * isqrt(d2);
          gm = {96'd0, g_const} * {96'd0, it.om};
          acc_x = pull_axis(acc_x, dx, gm, d3, f);
          acc_y = pull_axis(acc_y, dy, gm, d3, f);
        end
      end
      OP_COLLIDE: begin
        if ({1'b0, m_own} + {1'b0, it.om} != 0) begin
          vel_x = bounce_axis(vel_x, it.ovx, it.om, f);
          vel_y = bounce_axis(vel_y, it.ovy, it.om, f);
        end
      end
      OP_INTEGRATE: begin
        if (!body_fix) begin
          vel_x = clip32(128'(vel_x) + 128'(acc_x), f);
          vel_y = clip32(128'(vel_y) + 128'(acc_y), f);
          pos_x = clip32(128'(pos_x) + 128'(vel_x), f);
          pos_y = clip32(128'(pos_y) + 128'(vel_y), f);
        end
      end
      default: begin
        acc_x = 0;
        acc_y = 0;
      end
    endcase
    r.px = pos_x;
    r.py = pos_y;
    r.vx = vel_x;
    r.vy = vel_y;
    r.sat = f;
    expected_states.insert(expected_states.size(), r);
  endtask

  // driver
  always @(posedge clk) begin
    body_item_t it;
    int gap_n;
    bit holding;
    if (!rst_n) begin
      in_valid <= 0;
      gap <= 0;
    end else begin
      gap_n = gap;
      holding = in_valid;
      if (in_valid && !in_stall) begin
        step_body(cur);
        holding = 0;
        gap_n = calm ? 0 : $urandom_range(0, 5);
      end
      if (!holding) begin
        if (gap_n > 0) begin
          gap_n--;
          in_valid <= 0;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          if (popped % 40 == 0) calm = ($urandom_range(0, 3) == 0);
          popped++;
          // aim near the body as it will be when this item is taken
          if (it.near) begin
            it.ox = pos_x + it.ox;
            it.oy = pos_y + it.oy;
          end
          cur <= it;
          in_op <= it.op;
          in_other_x <= it.ox;
          in_other_y <= it.oy;
          in_other_mass <= it.om;
          in_other_vx <= it.ovx;
          in_other_vy <= it.ovy;
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end
      gap <= gap_n;
    end
  end

  // monitor
  always @(posedge clk) begin
    body_state_t e;
    int s;
    if (!rst_n) begin
      out_stall <= 0;
      stall_left <= 0;
    end else begin
      s = stall_left;
      if (out_valid && !out_stall) begin
        if (expected_states.size() == 0) begin
          $error("result with none expected");
          fails++;
        end else begin
          e = expected_states.pop_front();
          if (out_pos_x !== e.px) begin
            $error("pos_x exp %h got %h", e.px, out_pos_x); fails++;
          end
          if (out_pos_y !== e.py) begin
            $error("pos_y exp %h got %h", e.py, out_pos_y); fails++;
          end
          if (out_vel_x !== e.vx) begin
            $error("vel_x exp %h got %h", e.vx, out_vel_x); fails++;
          end
          if (out_vel_y !== e.vy) begin
            $error("vel_y exp %h got %h", e.vy, out_vel_y); fails++;
          end
          if (out_zero_distance !== e.zd) begin
            $error("zero_distance exp %b got %b", e.zd, out_zero_distance); fails++;
          end
          if (out_saturated !== e.sat) begin
            $error("saturated exp %b got %b", e.sat, out_saturated); fails++;
          end
        end
        s = calm ? 0 : $urandom_range(0, 5);
      end
      if (s > 0) begin
        out_stall <= 1;
        s--;
      end else begin
        out_stall <= 0;
      end
      stall_left <= s;
    end
  end

  // watchdog: count cycles where work is pending yet nothing moves
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (!in_valid && expected_states.size() == 0))
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL gravity_body_integrator_core");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic write_reg(input int idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_penable <= 0;
    cfg_paddr <= gbi_pkg::AW'(idx * 4);
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    case (idx)
      REG_GRAV:     g_const = val;
      REG_MASS:     m_own = val;
      REG_FIXED:    body_fix = val[0];
      REG_START_X:  pos_x = val;
      REG_START_Y:  pos_y = val;
      REG_START_VX: vel_x = val;
      REG_START_VY: vel_y = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_states.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 32'h4_0000);
      2: return -$urandom_range(0, 32'h4_0000);
      3: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom_range(0, 32'h100);
    endcase
  endfunction

  task automatic add_item(input logic [1:0] op, input logic [31:0] ox, input logic [31:0] oy,
      input logic [31:0] om, input logic [31:0] ovx, input logic [31:0] ovy, input bit near);
    body_item_t it;
    it.op = op;
    it.ox = ox;
    it.oy = oy;
    it.om = om;
    it.ovx = ovx;
    it.ovy = ovy;
    it.near = near;
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic add_random(input int n);
    logic [1:0] op;
    bit near;
    for (int i = 0; i < n; i++) begin
      op = $urandom_range(0, 3);
      near = (op == OP_ATTRACT) && ($urandom_range(0, 3) != 0);
      if (near && $urandom_range(0, 9) == 0)
        add_item(op, 0, 0, pick32(), pick32(), pick32(), 1);
      else if (near)
        add_item(op, $signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000,
                 $signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000,
                 pick32(), pick32(), pick32(), 1);
      else
        add_item(op, pick32(), pick32(), pick32(), pick32(), pick32(), 0);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;

    // directed: body at origin after reset
    add_item(OP_ATTRACT, 0, 0, 32'h1_0000, 0, 0, 0);
    add_item(OP_ATTRACT, 32'h1_0000, 0, 32'h1_0000, 0, 0, 0);
    add_item(OP_ATTRACT, 0, 32'h8000_0000, 32'hffff_ffff, 0, 0, 0);
    add_item(OP_ATTRACT, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 0, 0, 0);
    add_item(OP_ATTRACT, 1, 1, 32'hffff_ffff, 0, 0, 0);
    add_item(OP_INTEGRATE, 0, 0, 0, 0, 0, 0);
    add_item(OP_INTEGRATE, 0, 0, 0, 0, 0, 0);
    add_item(OP_CLEAR, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
             32'hffff_ffff, 0);
    add_item(OP_COLLIDE, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 0);
    add_item(OP_COLLIDE, 0, 0, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0);
    add_item(OP_COLLIDE, 0, 0, 32'h1_0000, 32'h3_0000, -32'sh2_0000, 0);
    add_item(OP_ATTRACT, 0, 0, 32'h1_0000, 0, 0, 1);
    add_item(OP_INTEGRATE, 0, 0, 0, 0, 0, 0);
    add_random(120);
    drain();

    write_reg(REG_GRAV, 32'hffff_ffff);
    write_reg(REG_MASS, 32'd1);
    write_reg(REG_START_X, 32'h7fff_ffff);
    write_reg(REG_START_Y, 32'h8000_0000);
    write_reg(REG_START_VX, 32'h7fff_ffff);
    write_reg(REG_START_VY, 32'h8000_0000);
    write_reg(REG_UNUSED, 32'hdead_beef);
    add_item(OP_INTEGRATE, 0, 0, 0, 0, 0, 0);
    add_item(OP_ATTRACT, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 0, 0, 0);
    add_random(140);
    drain();

    write_reg(REG_FIXED, 1);
    write_reg(REG_GRAV, 32'd0);
    write_reg(REG_MASS, 32'hffff_ffff);
    add_item(OP_ATTRACT, 5, 5, 32'hffff_ffff, 0, 0, 0);
    add_item(OP_INTEGRATE, 0, 0, 0, 0, 0, 0);
    add_random(140);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_FIXED, $urandom_range(0, 1));
      write_reg(REG_GRAV, ph == 0 ? 32'h1_0000 : pick32());
      write_reg(REG_MASS, $urandom_range(1, 32'hffff_ffff));
      write_reg(REG_START_X, pick32());
      write_reg(REG_START_Y, pick32());
      write_reg(REG_START_VX, pick32());
      write_reg(REG_START_VY, pick32());
      add_random(140);
      drain();
    end

    repeat (20) @(posedge clk);
    if (fails == 0)
      $display("PASS gravity_body_integrator_core");
    else
      $display("FAIL gravity_body_integrator_core");
    $finish;
  end

endmodule
